// ----- rtl/core/mactf_pkg.sv -----
// Shared types, constants and the microcode program of the Ethernet address text formatter.
// Depends on nothing; the top, the sequencer and the datapath refer to it by scoped names.
package mactf_pkg;

  localparam int unsigned PC_W = 6;
  localparam int unsigned PROG_DEPTH = 60;

  // Format codes of the output_format register.
  localparam logic [2:0] FMT_DASH_UPPER = 3'd0;
  localparam logic [2:0] FMT_COLON_LOWER = 3'd1;
  localparam logic [2:0] FMT_COLON_UNPAD = 3'd2;
  localparam logic [2:0] FMT_DOTTED = 3'd3;
  localparam logic [2:0] FMT_DASH_LOWER = 3'd4;
  localparam logic [2:0] FMT_PACKED_UPPER = 3'd5;
  localparam logic [2:0] FMT_PACKED_LOWER = 3'd6;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_PADDED = 6'd0;
  localparam logic [PC_W-1:0] PC_UNPAD = 6'd17;
  localparam logic [PC_W-1:0] PC_DOTTED = 6'd34;
  localparam logic [PC_W-1:0] PC_PACKED = 6'd48;

  // Buffer sizes needed, terminator included.
  localparam logic [4:0] NEED_SEP = 5'd18;
  localparam logic [4:0] NEED_DOTTED = 5'd15;
  localparam logic [4:0] NEED_PACKED = 5'd13;

  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    OP_HEX,     // emit the top nibble as a digit and shift it out
    OP_HEX_NZ,  // same, but skip the emit when the nibble is zero
    OP_SEP      // emit the separator character
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } ctrl_word_t;

  typedef struct packed {
    logic       load_addr;
    logic       step;
    logic       err;
    ctrl_word_t cw;
  } seq_ctrl_t;

  typedef struct packed {
    logic [PC_W-1:0] entry;
    logic [4:0]      need;
    logic            upper;
    logic [7:0]      sep;
  } fmt_info_t;

  localparam ctrl_word_t CW_H = '{op: OP_HEX, last: 1'b0};
  localparam ctrl_word_t CW_HL = '{op: OP_HEX, last: 1'b1};
  localparam ctrl_word_t CW_Z = '{op: OP_HEX_NZ, last: 1'b0};
  localparam ctrl_word_t CW_S = '{op: OP_SEP, last: 1'b0};

  localparam ctrl_word_t PROG_ROM [PROG_DEPTH] = '{
    // Padded with separators: dash and colon styles.
    CW_H, CW_H, CW_S, CW_H, CW_H, CW_S, CW_H, CW_H, CW_S,
    CW_H, CW_H, CW_S, CW_H, CW_H, CW_S, CW_H, CW_HL,
    // Unpadded colon style.
    CW_Z, CW_H, CW_S, CW_Z, CW_H, CW_S, CW_Z, CW_H, CW_S,
    CW_Z, CW_H, CW_S, CW_Z, CW_H, CW_S, CW_Z, CW_HL,
    // Dotted groups of four.
    CW_H, CW_H, CW_H, CW_H, CW_S, CW_H, CW_H, CW_H, CW_H, CW_S,
    CW_H, CW_H, CW_H, CW_HL,
    // Packed.
    CW_H, CW_H, CW_H, CW_H, CW_H, CW_H, CW_H, CW_H, CW_H, CW_H,
    CW_H, CW_HL
  };

  function automatic fmt_info_t fmt_decode(input logic [2:0] fmt);
    fmt_info_t info;
    info = '{entry: PC_PADDED, need: NEED_SEP, upper: 1'b1, sep: CHAR_DASH};
    case (fmt)
      FMT_COLON_LOWER: begin
        info = '{entry: PC_PADDED, need: NEED_SEP, upper: 1'b0, sep: CHAR_COLON};
      end
      FMT_COLON_UNPAD: begin
        info = '{entry: PC_UNPAD, need: NEED_SEP, upper: 1'b0, sep: CHAR_COLON};
      end
      FMT_DOTTED: begin
        info = '{entry: PC_DOTTED, need: NEED_DOTTED, upper: 1'b0, sep: CHAR_DOT};
      end
      FMT_DASH_LOWER: begin
        info = '{entry: PC_PADDED, need: NEED_SEP, upper: 1'b0, sep: CHAR_DASH};
      end
      FMT_PACKED_UPPER: begin
        info = '{entry: PC_PACKED, need: NEED_PACKED, upper: 1'b1, sep: CHAR_NUL};
      end
      FMT_PACKED_LOWER: begin
        info = '{entry: PC_PACKED, need: NEED_PACKED, upper: 1'b0, sep: CHAR_NUL};
      end
      default: begin
        info = '{entry: PC_PADDED, need: NEED_SEP, upper: 1'b1, sep: CHAR_DASH};
      end
    endcase
    return info;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? 8'h37 : 8'h57;
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return base + {4'd0, nib};
  endfunction

endpackage

// ----- rtl/core/mactf_ifs.sv -----
// Channel interfaces of the Ethernet address text formatter: request input, result output
// and configuration write. Depends on nothing.
interface mactf_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] mac_address;
  logic [7:0]  buffer_capacity;
  modport source (output valid, output mac_address, output buffer_capacity, input ready);
  modport sink (input valid, input mac_address, input buffer_capacity, output ready);
endinterface

interface mactf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       status;
  modport source (output valid, output character, output last, output status, input ready);
  modport sink (input valid, input character, input last, input status, output ready);
endinterface

interface mactf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] output_format;
  modport source (output valid, output output_format, input ready);
  modport sink (input valid, input output_format, output ready);
endinterface

// ----- rtl/core/mac_address_text_formatter_top.sv -----
// Ethernet address text formatter. Each request carries a 48-bit address (first printed
// octet in bits 47..40) and a buffer capacity; the block returns the address as ASCII text,
// one character per result, with last set on the final one. The style comes from the
// output_format register: 0 and 7 dash upper, 1 colon lower, 2 colon unpadded, 3 dotted,
// 4 dash lower, 5 packed upper, 6 packed lower. If the capacity is below 18 (dash and colon),
// 15 (dotted) or 13 (packed), one result with character 0, last 1 and status 1 comes instead.
// A microcode program runs one step per cycle while the result register can take a result:
// 17 steps for the dash and colon styles (the unpadded style spends a step without a result
// on each skipped leading zero), 14 for dotted, 12 for packed and one for an error.
// The next request is taken once the previous program ends; its last result may still wait.
// Depends on mactf_pkg, mactf_ifs, mactf_seq and mactf_dp.
module mac_address_text_formatter_top (
  input  logic        clk,
  input  logic        rst_n,
  mactf_in_if.sink    in_ch,
  mactf_out_if.source out_ch,
  mactf_cfg_if.sink   cfg_ch
);

  logic [2:0]           fmt_r;
  logic                 slot_free;
  mactf_pkg::seq_ctrl_t ctrl;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= mactf_pkg::FMT_DASH_UPPER;
    end else if (cfg_ch.valid) begin
      fmt_r <= cfg_ch.output_format;
    end
  end

  mactf_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .fmt             (fmt_r),
    .in_valid        (in_ch.valid),
    .buffer_capacity (in_ch.buffer_capacity),
    .slot_free       (slot_free),
    .in_ready        (in_ch.ready),
    .ctrl            (ctrl)
  );

  mactf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .fmt           (fmt_r),
    .mac_address   (in_ch.mac_address),
    .out_ready     (out_ch.ready),
    .slot_free     (slot_free),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_last      (out_ch.last),
    .out_status    (out_ch.status)
  );

`ifndef SYNTHESIS
  // A taken request keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while the previous program was still starting");

  // An error result is always a single NUL character that closes the request.
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.last && out_ch.character == mactf_pkg::CHAR_NUL)
    else $error("error result without last or with a nonzero character");
`endif

endmodule

// ----- rtl/core/mactf_dp.sv -----
// Datapath of the formatter: address shift register, character generation and the
// result register. Depends on mactf_pkg.
module mactf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mactf_pkg::seq_ctrl_t ctrl,
  input  logic [2:0]           fmt,
  input  logic [47:0]          mac_address,
  input  logic                 out_ready,
  output logic                 slot_free,
  output logic                 out_valid,
  output logic [7:0]           out_character,
  output logic                 out_last,
  output logic                 out_status
);

  mactf_pkg::fmt_info_t info;
  logic [47:0] addr_r, addr_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        last_r, last_nxt;
  logic        status_r, status_nxt;
  logic [3:0]  nib;
  logic        emit;

  assign info = mactf_pkg::fmt_decode(fmt);
  assign nib = addr_r[47:44];
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    case (ctrl.cw.op)
      mactf_pkg::OP_HEX:    emit = 1'b1;
      mactf_pkg::OP_HEX_NZ: emit = (nib != 4'd0);
      mactf_pkg::OP_SEP:    emit = 1'b1;
      default:              emit = 1'b0;
    endcase
  end

  always_comb begin
    addr_nxt = addr_r;
    valid_nxt = valid_r && !out_ready;
    char_nxt = char_r;
    last_nxt = last_r;
    status_nxt = status_r;
    if (ctrl.load_addr) begin
      addr_nxt = mac_address;
    end else if (ctrl.step && ctrl.cw.op != mactf_pkg::OP_SEP) begin
      addr_nxt = {addr_r[43:0], 4'd0};
    end
    if (ctrl.err) begin
      valid_nxt = 1'b1;
      char_nxt = mactf_pkg::CHAR_NUL;
      last_nxt = 1'b1;
      status_nxt = 1'b1;
    end else if (ctrl.step && emit) begin
      valid_nxt = 1'b1;
      char_nxt = (ctrl.cw.op == mactf_pkg::OP_SEP) ? info.sep
                                                   : mactf_pkg::hex_char(nib, info.upper);
      last_nxt = ctrl.cw.last;
      status_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    addr_r <= addr_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    status_r <= status_nxt;
  end

  assign out_valid = valid_r;
  assign out_character = char_r;
  assign out_last = last_r;
  assign out_status = status_r;

endmodule

// ----- rtl/core/mactf_seq.sv -----
// Microcode sequencer of the formatter: step counter, program ROM lookup and the
// idle/run/error control. Depends on mactf_pkg.
module mactf_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           fmt,
  input  logic                 in_valid,
  input  logic [7:0]           buffer_capacity,
  input  logic                 slot_free,
  output logic                 in_ready,
  output mactf_pkg::seq_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ERR
  } state_t;

  state_t                         state_r;
  logic [mactf_pkg::PC_W-1:0]     pc_r;
  mactf_pkg::fmt_info_t           info;
  mactf_pkg::ctrl_word_t          cw;
  logic                           accept;

  assign info = mactf_pkg::fmt_decode(fmt);
  assign cw = mactf_pkg::PROG_ROM[pc_r];
  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    ctrl.load_addr = accept;
    ctrl.step = (state_r == S_RUN) && slot_free;
    ctrl.err = (state_r == S_ERR) && slot_free;
    ctrl.cw = cw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (buffer_capacity < {3'd0, info.need}) begin
              state_r <= S_ERR;
            end else begin
              state_r <= S_RUN;
              pc_r <= info.entry;
            end
          end
        end
        S_RUN: begin
          if (slot_free) begin
            if (cw.last) begin
              state_r <= S_IDLE;
            end else begin
              pc_r <= pc_r + 1'b1;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
